// ----- hw/rtl/ascii_number_parser_unit_defines.svh -----
// ----------------------------------------------------------------------------
// ASCII number parser assertion macros
// Concurrent assertion helpers for the parser; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASCII_NUMBER_PARSER_UNIT_DEFINES_SVH
`define ASCII_NUMBER_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while the block is out of reset.
`define ANP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define ANP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define ANP_ASSERT(name, prop)
`define ANP_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ----- hw/rtl/anp_pkg.sv -----
// ----------------------------------------------------------------------------
// ASCII number parser package
// Shared types, codes and a helper function of the parser.
// ----------------------------------------------------------------------------
package anp_pkg;

  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_BIN  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } anp_base_e;

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2,
    WIDTH_64 = 2'd3
  } anp_width_e;

  // Configuration register indexes.
  localparam logic CfgNumberBase = 1'b0;
  localparam logic CfgValueWidth = 1'b1;

  // Character position within the string; saturates at the later code.
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosLater  = 2'd2;

  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [7:0] CharUpF   = 8'h46;  // 'F'
  localparam logic [7:0] CharLoA   = 8'h61;  // 'a'
  localparam logic [7:0] CharLoF   = 8'h66;  // 'f'
  localparam logic [7:0] CharUpOff = 8'h37;  // 'A' - 10
  localparam logic [7:0] CharLoOff = 8'h57;  // 'a' - 10
  localparam logic [7:0] CharB     = 8'h62;  // 'b'
  localparam logic [7:0] CharX     = 8'h78;  // 'x'

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } anp_digit_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [63:0] value;
  } anp_result_t;

  function automatic logic [63:0] width_max(anp_width_e w);
    logic [63:0] m;
    unique case (w)
      WIDTH_8:  m = 64'h0000_0000_0000_00FF;
      WIDTH_16: m = 64'h0000_0000_0000_FFFF;
      WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- hw/rtl/anp_char_decode.sv -----
// ----------------------------------------------------------------------------
// ASCII number parser character decoder
// Maps one character to a digit value and checks it against the base.
// ----------------------------------------------------------------------------
module anp_char_decode (
  input  logic [7:0]          char_i,
  input  anp_pkg::anp_base_e  base_i,
  output anp_pkg::anp_digit_t digit_o
);
  import anp_pkg::*;

  logic       is_char;
  logic [7:0] diff;
  logic       in_radix;

  always_comb begin
    is_char = 1'b1;
    diff    = 8'd0;
    priority if (char_i >= CharZero && char_i <= CharNine) begin
      diff = char_i - CharZero;
    end else if (char_i >= CharUpA && char_i <= CharUpF) begin
      diff = char_i - CharUpOff;
    end else if (char_i >= CharLoA && char_i <= CharLoF) begin
      diff = char_i - CharLoOff;
    end else begin
      is_char = 1'b0;
    end

    unique case (base_i)
      BASE_BIN: in_radix = (diff[3:0] < 4'd2);
      BASE_HEX: in_radix = 1'b1;
      default:  in_radix = (diff[3:0] < 4'd10);
    endcase

    digit_o.ok    = is_char && in_radix;
    digit_o.value = diff[3:0];
  end

endmodule

// ----- hw/rtl/anp_step.sv -----
// ----------------------------------------------------------------------------
// ASCII number parser step
// String state and the per-character update, with the verdict at the end.
// ----------------------------------------------------------------------------
module anp_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           char_i,
  input  logic                 last_i,
  input  logic                 empty_i,
  input  anp_pkg::anp_base_e   number_base_i,
  input  anp_pkg::anp_width_e  value_width_i,
  output anp_pkg::anp_result_t result_o
);
  import anp_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic [1:0]  pos_q, pos_d;
  anp_base_e   base_q, base_d;
  logic        seen_q, seen_d;
  logic        failed_q, failed_d;

  anp_base_e   take_base;
  logic        do_take;
  anp_digit_t  digit;
  logic [67:0] prod;
  logic [68:0] sum;
  logic [63:0] max;
  logic        first_auto;
  logic        prefix_pending;

  anp_char_decode u_decode (
    .char_i  (char_i),
    .base_i  (take_base),
    .digit_o (digit)
  );

  always_comb begin
    max            = width_max(value_width_i);
    first_auto     = (pos_q == PosFirst) && (number_base_i == BASE_AUTO);
    prefix_pending = (pos_q == PosSecond) && (base_q == BASE_AUTO);

    if (pos_q == PosFirst) begin
      take_base = first_auto ? BASE_DEC : number_base_i;
    end else if (prefix_pending) begin
      take_base = BASE_DEC;
    end else begin
      take_base = base_q;
    end

    // A leading zero in automatic mode and a prefix letter are not digits.
    do_take = !failed_q
           && !(first_auto && (last_i || char_i == CharZero))
           && !(prefix_pending && (char_i == CharB || char_i == CharX));

    unique case (take_base)
      BASE_BIN: prod = {3'b000, acc_q, 1'b0};
      BASE_HEX: prod = {acc_q, 4'b0000};
      default:  prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
    endcase
    sum = {1'b0, prod} + {65'd0, digit.value};

    acc_d    = acc_q;
    pos_d    = pos_q;
    base_d   = base_q;
    seen_d   = seen_q;
    failed_d = failed_q;
    result_o = '0;

    if (empty_i) begin
      acc_d          = '0;
      pos_d          = PosFirst;
      base_d         = BASE_AUTO;
      seen_d         = 1'b0;
      failed_d       = 1'b0;
      result_o.valid = 1'b1;
    end else begin
      if (!failed_q) begin
        if (pos_q == PosFirst) begin
          if (!first_auto) begin
            base_d = number_base_i;
          end else if (last_i) begin
            failed_d = 1'b1;
          end else if (char_i != CharZero) begin
            base_d = BASE_DEC;
          end
        end else if (prefix_pending) begin
          if (char_i == CharB) begin
            base_d = BASE_BIN;
          end else if (char_i == CharX) begin
            base_d = BASE_HEX;
          end else begin
            base_d = BASE_DEC;
          end
        end
      end

      if (do_take) begin
        // Overflow is checked on the full-width product and sum.
        if (!digit.ok || sum > {5'd0, max}) begin
          failed_d = 1'b1;
        end else begin
          acc_d  = sum[63:0];
          seen_d = 1'b1;
        end
      end

      if (pos_q != PosLater) begin
        pos_d = pos_q + 2'd1;
      end

      if (last_i) begin
        result_o.valid = 1'b1;
        result_o.ok    = !failed_d && seen_d && (acc_d <= max);
        result_o.value = result_o.ok ? acc_d : 64'd0;
        acc_d          = '0;
        pos_d          = PosFirst;
        base_d         = BASE_AUTO;
        seen_d         = 1'b0;
        failed_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pos_q    <= PosFirst;
      base_q   <= BASE_AUTO;
      seen_q   <= 1'b0;
      failed_q <= 1'b0;
    end else if (fire_i) begin
      acc_q    <= acc_d;
      pos_q    <= pos_d;
      base_q   <= base_d;
      seen_q   <= seen_d;
      failed_q <= failed_d;
    end
  end

endmodule

// ----- hw/rtl/ascii_number_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ASCII number parser unit
// Streams the characters of a string and reports its unsigned value.
// ----------------------------------------------------------------------------
// Characters arrive on the s_axis channel, one request per character, with
// tlast on the final one; tuser set marks an empty string. Each string yields
// one result request on m_axis: tuser is the verdict (1 when the string is a
// valid number in range) and tdata the value, or zero when it is not valid.
// The cfg channel writes number_base (index 0) and value_width (index 1);
// it is always ready and must only be used while no string is in flight.
// A character is registered on acceptance and processed from the input
// register, where one multiply by the base and add update the accumulator
// when the output register can take a result; the result of a string is
// registered in the output register, from which the receiver takes it.
// One character is taken every cycle while the receiver does not stall.
// When the receiver stalls, the result stays in the output register and
// the input register holds one more character before tready drops. Reset
// clears the string state, empties both registers and sets automatic base
// and 64-bit width.
`include "ascii_number_parser_unit_defines.svh"

module ascii_number_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // [0] empty_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] parsed_value
  output logic        m_axis_tuser,   // [0] parse_ok
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [1:0]  cfg_data_i
);
  import anp_pkg::*;

  anp_base_e   number_base_q;
  anp_width_e  value_width_q;

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_last_q;
  logic        in_empty_q;

  logic        out_valid_q;
  logic        out_ok_q;
  logic [63:0] out_value_q;

  logic        fire;
  anp_result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_AUTO;
      value_width_q <= WIDTH_64;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNumberBase: number_base_q <= anp_base_e'(cfg_data_i);
        default:       value_width_q <= anp_width_e'(cfg_data_i);
      endcase
    end
  end

  // The processing stage advances when the output register can take a result.
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q  <= s_axis_tdata;
      in_last_q  <= s_axis_tlast;
      in_empty_q <= s_axis_tuser;
    end
  end

  anp_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .char_i        (in_char_q),
    .last_i        (in_last_q),
    .empty_i       (in_empty_q),
    .number_base_i (number_base_q),
    .value_width_i (value_width_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= result.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && result.valid) begin
      out_ok_q    <= result.ok;
      out_value_q <= result.value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = out_value_q;

  `ANP_ASSERT(a_fail_value_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
  `ANP_ASSERT(a_stall_blocks_input,
              in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
  `ANP_ASSERT(a_result_needs_item, $rose(m_axis_tvalid) |-> $past(in_valid_q))
  `ANP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid && !in_valid_q)

endmodule

// ----- tb/ascii_number_parser_unit_checker.sv -----
// ----------------------------------------------------------------------------
// ASCII number parser checker
// Watches the character, result and register channels of the parser, keeps
// its own model of the string state and compares every result request with
// the verdict predicted for it.
// ----------------------------------------------------------------------------
module ascii_number_parser_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_char_i,
  input  logic        s_last_i,
  input  logic        s_empty_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_value_i,
  input  logic        m_ok_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  output int          pending_o,
  output int          fail_count_o,
  output int          checked_o,
  output int          ok_count_o
);
  import anp_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [63:0] value;
  } verdict_t;

  verdict_t   verdict_q[$];

  anp_base_e  base_reg;
  anp_width_e width_reg;

  logic [63:0] acc;
  logic [1:0]  pos;
  anp_base_e   act_base;
  logic        seen_digit;
  logic        bad;

  function automatic logic [63:0] value_limit(anp_width_e w);
    if (w == WIDTH_64) return '1;
    return (64'd1 << (8 << w)) - 64'd1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic clear_string();
    acc = '0;
    pos = PosFirst;
    act_base = BASE_AUTO;
    seen_digit = 1'b0;
    bad = 1'b0;
  endtask

  // One digit into the accumulator; any illegal digit or overflow marks
  // the string as failed until it ends.
  task automatic take_digit(logic [7:0] c);
    logic [63:0] lim;
    logic [63:0] radix;
    int          d;
    lim = value_limit(width_reg);
    radix = (act_base == BASE_BIN) ? 64'd2 : (act_base == BASE_HEX) ? 64'd16 : 64'd10;
    if (c >= CharZero && c <= CharNine) d = int'(c - CharZero);
    else if (c >= CharUpA && c <= CharUpF) d = int'(c - CharUpOff);
    else if (c >= CharLoA && c <= CharLoF) d = int'(c - CharLoOff);
    else d = 16;
    if (d >= int'(radix)) bad = 1'b1;
    else if (acc > lim / radix) bad = 1'b1;
    else if (acc * radix > lim - 64'(d)) bad = 1'b1;
    else begin
      acc = acc * radix + 64'(d);
      seen_digit = 1'b1;
    end
  endtask

  task automatic parse_char(logic [7:0] c, logic last, logic empty);
    verdict_t v;
    if (empty) begin
      clear_string();
      verdict_q.push_back('0);
      return;
    end
    if (!bad) begin
      if (pos == PosFirst) begin
        if (base_reg != BASE_AUTO) begin
          act_base = base_reg;
          take_digit(c);
        end else if (last) begin
          bad = 1'b1;
        end else if (c == CharZero) begin
          act_base = BASE_AUTO;
        end else begin
          act_base = BASE_DEC;
          take_digit(c);
        end
      end else if (pos == PosSecond && act_base == BASE_AUTO) begin
        if (c == CharB) act_base = BASE_BIN;
        else if (c == CharX) act_base = BASE_HEX;
        else begin
          act_base = BASE_DEC;
          take_digit(c);
        end
      end else begin
        take_digit(c);
      end
    end
    if (pos != PosLater) pos = pos + 2'd1;
    if (last) begin
      // The width may have changed since the last digit, so check again.
      v.ok = !bad && seen_digit && acc <= value_limit(width_reg);
      v.value = v.ok ? acc : '0;
      verdict_q.push_back(v);
      clear_string();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      base_reg = BASE_AUTO;
      width_reg = WIDTH_64;
      clear_string();
      verdict_q.delete();
      pending_o = 0;
      fail_count_o = 0;
      checked_o = 0;
      ok_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgNumberBase) base_reg = anp_base_e'(cfg_data_i);
        else width_reg = anp_width_e'(cfg_data_i);
      end
      if (m_valid_i && m_ready_i) begin
        checked_o++;
        if (m_ok_i) ok_count_o++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no string pending", m_value_i, '0);
        end else begin
          want = verdict_q.pop_front();
          if (m_ok_i !== want.ok)
            report_mismatch("verdict", 64'(m_ok_i), 64'(want.ok));
          if (m_value_i !== want.value)
            report_mismatch("value", m_value_i, want.value);
        end
      end
      if (s_valid_i && s_ready_i) parse_char(s_char_i, s_last_i, s_empty_i);
      pending_o = verdict_q.size();
    end
  end

endmodule

// ----- tb/ascii_number_parser_unit_test.sv -----
// ----------------------------------------------------------------------------
// ASCII number parser testbench
// Feeds directed and random strings in every base and width setting, with
// random gaps and back-pressure, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module ascii_number_parser_unit_test;
  import anp_pkg::*;

  localparam int TotalItems = 1300;
  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [1:0]  cfg_data_i = '0;

  int pending;
  int fail_count;
  int checked;
  int ok_count;

  int          cycle_count = 0;
  int          items_sent = 0;
  int          strings_sent = 0;
  int          stall_left = 0;
  logic        idle_en = 1'b1;
  logic        quiet = 1'b0;
  anp_base_e   cur_base = BASE_AUTO;
  anp_width_e  cur_width = WIDTH_64;
  logic [7:0]  text_q[$];

  ascii_number_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ascii_number_parser_unit_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_char_i     (s_axis_tdata),
    .s_last_i     (s_axis_tlast),
    .s_empty_i    (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_value_i    (m_axis_tdata),
    .m_ok_i       (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .checked_o    (checked),
    .ok_count_o   (ok_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver back-pressure: random stalls between runs of ready.
  always @(negedge clk_i) begin
    if (quiet || !idle_en) begin
      m_axis_tready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (!m_axis_tready) begin
      m_axis_tready = 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(0, 14);
    end
  end

  task automatic send_item(logic [7:0] c, logic last, logic empty);
    if (idle_en && !quiet && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = c;
    s_axis_tlast = last;
    s_axis_tuser = empty;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_empty();
    send_item(8'($urandom), 1'($urandom), 1'b1);
    strings_sent++;
  endtask

  task automatic send_word(string s);
    foreach (s[i]) send_item(s[i], i == s.len() - 1, 1'b0);
    strings_sent++;
  endtask

  // Waits until every result has come back, then lets the clock run on so that
  // nothing is left in flight inside the block.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == CfgNumberBase) cur_base = anp_base_e'(data);
    else cur_width = anp_width_e'(data);
  endtask

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return CharZero + 8'(d);
    if ($urandom_range(0, 1) == 0) return CharUpA + 8'(d - 10);
    return CharLoA + 8'(d - 10);
  endfunction

  task automatic append_number(logic [64:0] v, int radix);
    logic [7:0] digs[$];
    do begin
      digs.push_front(digit_char(int'(v % radix)));
      v = v / radix;
    end while (v != 0);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) digs.push_front(CharZero);
    text_q = {text_q, digs};
  endtask

  // Builds one string in text_q: mostly well-formed numbers in the active
  // base, some near the width limit, the rest noise or damaged numbers.
  task automatic make_string();
    int          kind;
    int          radix;
    int          bits;
    int          n;
    logic [64:0] lim;
    logic [64:0] v;
    anp_base_e   b;
    text_q.delete();
    bits = 8 << cur_width;
    lim = (65'd1 << bits) - 65'd1;
    b = cur_base;
    if (cur_base == BASE_AUTO) begin
      b = anp_base_e'($urandom_range(1, 3));
      if (b == BASE_BIN) text_q = {CharZero, CharB};
      else if (b == BASE_HEX) text_q = {CharZero, CharX};
      else if ($urandom_range(0, 2) == 0) text_q.push_back(CharZero);
    end
    radix = (b == BASE_BIN) ? 2 : (b == BASE_HEX) ? 16 : 10;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      n = $urandom_range(1, bits);
      v = {1'b0, $urandom, $urandom} & ((65'd1 << n) - 65'd1);
      append_number(v, radix);
    end else if (kind < 70) begin
      if ($urandom_range(0, 1) == 0) v = lim - 65'($urandom_range(0, 2));
      else v = lim + 65'($urandom_range(1, 3));
      append_number(v, radix);
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(digit_char($urandom_range(0, 15)));
    end else if (kind < 90) begin
      text_q.delete();
      repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom));
    end else begin
      append_number(65'($urandom_range(0, 5000)), radix);
      if ($urandom_range(0, 2) == 0 && cur_base == BASE_AUTO && b != BASE_DEC)
        text_q = text_q[0:1];
      else
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
    end
  endtask

  // Sends text_q; now and then the string is cut short by an empty string.
  task automatic send_text();
    int cut;
    cut = text_q.size();
    if (cut > 1 && $urandom_range(0, 19) == 0) cut = $urandom_range(1, cut - 1);
    for (int i = 0; i < cut; i++)
      send_item(text_q[i], cut == text_q.size() && i == cut - 1, 1'b0);
    if (cut == text_q.size()) strings_sent++;
    else send_empty();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: automatic base, 64 bits.
    send_word("7");
    send_empty();
    send_word("0b");
    send_word("0xfF");
    send_item(CharZero, 1'b0, 1'b0);
    send_empty();
    send_word("09");
    settle();
    write_reg(CfgNumberBase, BASE_HEX);
    write_reg(CfgValueWidth, WIDTH_8);
    send_word("FF");
    send_word("100");
    settle();
    write_reg(CfgNumberBase, BASE_BIN);
    send_word("1");
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    settle();
    write_reg(CfgNumberBase, BASE_DEC);
    write_reg(CfgValueWidth, WIDTH_16);
    send_word("65535");

    while (items_sent < TotalItems) begin
      settle();
      if ($urandom_range(0, 2) != 0) write_reg(CfgNumberBase, 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) != 0) write_reg(CfgValueWidth, 2'($urandom_range(0, 3)));
      idle_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(4, 16)) begin
        if (items_sent < TotalItems) begin
          quiet = (items_sent > TotalItems - 150);
          if ($urandom_range(0, 24) == 0) begin
            send_empty();
          end else begin
            make_string();
            send_text();
          end
        end
      end
    end

    settle();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d characters in %0d strings; %0d results checked, %0d valid numbers.",
             items_sent, strings_sent, checked, ok_count);
    $display("Covered all bases and widths, prefixes, overflow, bad characters, empty strings.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
